FILE: rtl/core/lpfd_pkg.sv
`default_nettype none

package lpfd_pkg;

  // Header and length limits
  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] SYNC_END    = 8'h00;
  localparam logic [7:0] MAX_PAYLOAD = 8'd251;

  // Frame tracking state
  typedef enum logic [2:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_SYNC3,
    ST_LEN,
    ST_PAYLOAD
  } lpfd_state_t;

  // One result item from the parser to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
    logic       last_byte;
  } lpfd_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/length_prefixed_frame_deframer_unit.sv
`default_nettype none

// Channel   Direction  Ports
// in_       input      in_valid, in_ready, in_rx_byte
// out_      output     out_valid, out_ready, out_payload_byte, out_payload_index,
//                      out_frame_length, out_last_byte
//
// One item per cycle sustained while out_ready is high; a payload byte
// reaches out_ through the input register, then the result register.
// Header and length bytes and dropped frames give no result.
// Reset (rst_n low, synchronous) empties both registers and restarts the
// header search. A stall at out_ holds the result register and backs up
// into the input register, which drops in_ready only when both are full.

module length_prefixed_frame_deframer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_payload_byte,
  output logic [7:0]      out_payload_index,
  output logic [7:0]      out_frame_length,
  output logic            out_last_byte
);

  import lpfd_pkg::*;

  logic         byte_valid;
  logic [7:0]   byte_data;
  logic         room;
  logic         advance;
  lpfd_result_t result;

  // Consume the held byte when the result register has room
  assign advance = byte_valid && room;

  lpfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  lpfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (byte_data),
    .result  (result)
  );

  lpfd_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .result            (result),
    .load              (advance),
    .room              (room),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_length  (out_frame_length),
    .out_last_byte     (out_last_byte)
  );

endmodule

`default_nettype wire

FILE: rtl/core/lpfd_in_stage.sv
`default_nettype none

module lpfd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       advance,
  output logic            byte_valid,
  output logic [7:0]      byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // Take a new item when empty or when the held one moves on
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the byte until it is consumed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

`default_nettype wire

FILE: rtl/core/lpfd_parser.sv
`default_nettype none

module lpfd_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire logic [7:0]          rx_byte,
  output lpfd_pkg::lpfd_result_t   result
);

  import lpfd_pkg::*;

  lpfd_state_t state_r;
  lpfd_state_t state_nxt;
  logic        sync_ok_r;
  logic        sync_ok_nxt;
  logic [7:0]  index_r;
  logic [7:0]  index_nxt;
  logic [7:0]  length_r;
  logic [7:0]  length_nxt;
  logic        is_last;
  logic        len_ok;

  // Final byte when index + 1 reaches the held length
  assign is_last = ({1'b0, index_r} + 9'd1) >= {1'b0, length_r};
  assign len_ok  = (rx_byte != 8'd0) && (rx_byte <= MAX_PAYLOAD);

  // Next state
  always_comb begin
    state_nxt   = state_r;
    sync_ok_nxt = sync_ok_r;
    index_nxt   = index_r;
    length_nxt  = length_r;
    unique case (state_r)
      ST_SYNC1: begin
        sync_ok_nxt = (rx_byte == SYNC_BYTE);
        state_nxt   = ST_SYNC2;
      end
      ST_SYNC2: begin
        sync_ok_nxt = sync_ok_r && (rx_byte == SYNC_BYTE);
        state_nxt   = ST_SYNC3;
      end
      ST_SYNC3: begin
        state_nxt   = (sync_ok_r && (rx_byte == SYNC_END)) ? ST_LEN : ST_SYNC1;
        sync_ok_nxt = 1'b0;
      end
      ST_LEN: begin
        index_nxt = 8'd0;
        if (len_ok) begin
          length_nxt = rx_byte;
          state_nxt  = ST_PAYLOAD;
        end else begin
          length_nxt = 8'd0;
          state_nxt  = ST_SYNC1;
        end
      end
      ST_PAYLOAD: begin
        if (is_last) begin
          index_nxt  = 8'd0;
          length_nxt = 8'd0;
          state_nxt  = ST_SYNC1;
        end else begin
          index_nxt = index_r + 8'd1;
        end
      end
      default: begin
        state_nxt = ST_SYNC1;
      end
    endcase
  end

  // Result outputs
  always_comb begin
    result.valid         = 1'b0;
    result.payload_byte  = rx_byte;
    result.payload_index = index_r;
    result.frame_length  = length_r;
    result.last_byte     = is_last;
    unique case (state_r) inside
      ST_PAYLOAD: result.valid = 1'b1;
      ST_SYNC1, ST_SYNC2, ST_SYNC3, ST_LEN: result.valid = 1'b0;
      default: result.valid = 1'b0;
    endcase
  end

  // Advance frame state once per consumed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_SYNC1;
      sync_ok_r <= 1'b0;
      index_r   <= 8'd0;
      length_r  <= 8'd0;
    end else if (advance) begin
      state_r   <= state_nxt;
      sync_ok_r <= sync_ok_nxt;
      index_r   <= index_nxt;
      length_r  <= length_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lpfd_out_stage.sv
`default_nettype none

module lpfd_out_stage (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lpfd_pkg::lpfd_result_t result,
  input  wire logic                  load,
  output logic                       room,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_payload_byte,
  output logic [7:0]                 out_payload_index,
  output logic [7:0]                 out_frame_length,
  output logic                       out_last_byte
);

  import lpfd_pkg::*;

  logic         valid_r;
  logic         valid_nxt;
  lpfd_result_t data_r;
  logic         take;

  // Room when empty or when the waiting item is taken this cycle
  assign room = !valid_r || out_ready;
  assign take = load && result.valid;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= result;
    end
  end

  assign out_valid         = valid_r;
  assign out_payload_byte  = data_r.payload_byte;
  assign out_payload_index = data_r.payload_index;
  assign out_frame_length  = data_r.frame_length;
  assign out_last_byte     = data_r.last_byte;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench;
  import lpfd_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int FRAME_ITEMS   = 500;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_LIMIT   = 50;

  // One expected payload item
  typedef struct {
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] length;
    logic       last;
  } payload_item_t;

  // Track the header search and queue the payload items it lets through
  class payload_scoreboard;
    lpfd_state_t   phase;
    logic [7:0]    held_length;
    logic [7:0]    next_index;
    bit            sync1_ok;
    bit            sync2_ok;
    payload_item_t expected_q[$];
    int            mismatch_count;

    function new();
      restart();
      mismatch_count = 0;
    endfunction

    function void restart();
      phase       = ST_SYNC1;
      held_length = '0;
      next_index  = '0;
      sync1_ok    = 1'b0;
      sync2_ok    = 1'b0;
    endfunction

    function bit at_frame_start();
      return phase == ST_SYNC1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the frame tracker by one received byte
    function void note_rx_byte(logic [7:0] b);
      payload_item_t item;
      case (phase)
        ST_SYNC1: begin
          sync1_ok = (b == SYNC_BYTE);
          phase    = ST_SYNC2;
        end
        ST_SYNC2: begin
          sync2_ok = (b == SYNC_BYTE);
          phase    = ST_SYNC3;
        end
        // All three header bytes are judged together here
        ST_SYNC3: begin
          if (sync1_ok && sync2_ok && b == SYNC_END) phase = ST_LEN;
          else restart();
        end
        // Drop the frame on a zero or oversized length
        ST_LEN: begin
          if (b == 8'd0 || b > MAX_PAYLOAD) begin
            restart();
          end else begin
            held_length = b;
            next_index  = '0;
            phase       = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          item.data   = b;
          item.index  = next_index;
          item.length = held_length;
          item.last   = (int'(next_index) + 1 >= int'(held_length));
          expected_q.push_back(item);
          if (item.last) restart();
          else next_index = next_index + 8'd1;
        end
        default: restart();
      endcase
    endfunction

    task report_mismatch(string what);
      if (mismatch_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
    endtask

    // Compare one delivered item with the oldest expectation
    task check_payload(input logic [7:0] data, input logic [7:0] index,
                       input logic [7:0] length, input logic last);
      payload_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected payload byte %02h index %0d length %0d",
                                  data, index, length));
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data)
        report_mismatch($sformatf("payload_byte %02h, want %02h", data, want.data));
      if (index !== want.index)
        report_mismatch($sformatf("payload_index %0d, want %0d", index, want.index));
      if (length !== want.length)
        report_mismatch($sformatf("frame_length %0d, want %0d", length, want.length));
      if (last !== want.last)
        report_mismatch($sformatf("last_byte %b, want %b at index %0d",
                                  last, want.last, want.index));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_payload_byte;
  logic [7:0] out_payload_index;
  logic [7:0] out_frame_length;
  logic       out_last_byte;

  int gap_rate     = 0;
  int stall_rate   = 0;
  bit hold_request = 1'b0;
  int cycle_count  = 0;

  payload_scoreboard scoreboard = new();

  length_prefixed_frame_deframer_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_length  (out_frame_length),
    .out_last_byte     (out_last_byte)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) scoreboard.note_rx_byte(in_rx_byte);
      if (out_valid && out_ready)
        scoreboard.check_payload(out_payload_byte, out_payload_index,
                                 out_frame_length, out_last_byte);
    end
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("length_prefixed_frame_deframer_unit verification failed");
      $finish;
    end
  end

  // Offer one byte, with an occasional idle burst ahead of it
  task automatic send_byte(input logic [7:0] value);
    if (gap_rate > 0 && $urandom_range(0, 15) < gap_rate) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_frame(input int length);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_END);
    send_byte(8'(length));
    repeat (length) send_byte(8'($urandom));
  endtask

  // Pad with zero bytes until the search is back at a frame boundary
  task automatic realign();
    while (!scoreboard.at_frame_start()) send_byte(8'h00);
  endtask

  task automatic wait_for_results();
    while (scoreboard.pending() != 0) @(negedge clk);
  endtask

  // Result side: ready and stall bursts, plus one long hold on request
  initial begin : receiver
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left  = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        burst_left--;
      end else begin
        out_ready  = !(stall_rate > 0 && $urandom_range(0, 15) < stall_rate);
        burst_left = $urandom_range(1, 14) - 1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] directed_q[$];
    logic [7:0] hdr [3];
    int         frame_items;
    int         kind;
    int         len;
    int         n;
    bit         hold_done;
    bit         full_done;
    bit         pause_done;
    frame_items = 0;
    hold_done   = 1'b0;
    full_done   = 1'b0;
    pause_done  = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: shortest frame, header mismatches, bad lengths, short frame
    directed_q = {8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00,
                  8'hFF, 8'h7F, 8'h00,
                  8'hFF, 8'hFF, 8'h01,
                  8'hFF, 8'hFF, 8'h00, 8'h00,
                  8'hFF, 8'hFF, 8'h00, 8'hFC,
                  8'hFF, 8'hFF, 8'h00, 8'h03, 8'hFF, 8'h80, 8'h7F};
    gap_rate   = 3;
    stall_rate = 3;
    foreach (directed_q[i]) send_byte(directed_q[i]);

    // Random: mostly well-formed frames, some noise and broken frames
    while (frame_items < FRAME_ITEMS) begin
      if (frame_items >= FRAME_ITEMS - 100) begin
        gap_rate   = 0;
        stall_rate = 0;
      end else if ($urandom_range(0, 7) == 0) begin
        gap_rate   = $urandom_range(0, 6);
        stall_rate = $urandom_range(0, 6);
      end

      if (!hold_done && frame_items >= 40) begin
        // Keep offering bytes while the result side is held off
        hold_done    = 1'b1;
        gap_rate     = 0;
        hold_request = 1'b1;
        send_frame(24);
        frame_items += 28;
      end else if (!full_done && frame_items >= 80) begin
        full_done = 1'b1;
        send_frame(int'(MAX_PAYLOAD));
        frame_items += int'(MAX_PAYLOAD) + 4;
      end else if (!pause_done && frame_items >= 360) begin
        // Let every pending item drain before going on
        pause_done = 1'b1;
        wait_for_results();
      end else begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          send_frame(len);
          frame_items += len + 4;
        end else if (kind == 7) begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 3;
          repeat (n) send_byte(8'($urandom));
          realign();
        end else if (kind == 8) begin
          // Corrupt one of the three header bytes
          hdr[0] = SYNC_BYTE;
          hdr[1] = SYNC_BYTE;
          hdr[2] = SYNC_END;
          n = $urandom_range(0, 2);
          hdr[n] = hdr[n] ^ 8'($urandom_range(1, 255));
          foreach (hdr[i]) send_byte(hdr[i]);
        end else begin
          // Zero length or one past the payload limit and beyond
          send_byte(SYNC_BYTE);
          send_byte(SYNC_BYTE);
          send_byte(SYNC_END);
          send_byte($urandom_range(0, 1) ? 8'h00
                                         : 8'($urandom_range(int'(MAX_PAYLOAD) + 1, 255)));
        end
      end
    end

    in_valid = 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scoreboard.mismatch_count == 0) begin
      $display("length_prefixed_frame_deframer_unit verification clean");
    end else begin
      $display("length_prefixed_frame_deframer_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lpfd_pkg.sv
rtl/core/lpfd_in_stage.sv
rtl/core/lpfd_parser.sv
rtl/core/lpfd_out_stage.sv
rtl/core/length_prefixed_frame_deframer_unit.sv
bench/testbench.sv
